@@ hdl/cbts_pkg.sv @@
// ----------------------------------------------------------------------------
// cbts_pkg
// Shared widths, constants, command type and capacitor ROM for the capacitor
// bank tuning search.
// ----------------------------------------------------------------------------
package cbts_pkg;

  localparam int TargetW         = 24;
  localparam int WordW           = 16;
  localparam int RomSize         = 16;
  localparam int RomIdxW         = 4;
  localparam int NumSwitchesDef  = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               start;     // capture target, clear the running total
    logic               step;      // decide the bit selected by idx
    logic               load_out;  // copy the decided word into the output register
    logic [RomIdxW-1:0] idx;       // bit under trial
  } cbts_cmd_t;

  // Capacitor values in whole picofarads, index 0 is the smallest.
  function automatic logic [TargetW-1:0] cap_pf(input logic [RomIdxW-1:0] idx);
    logic [TargetW-1:0] val;
    case (idx)
      4'd0:    val = 24'd150;
      4'd1:    val = 24'd330;
      4'd2:    val = 24'd680;
      4'd3:    val = 24'd1500;
      4'd4:    val = 24'd3300;
      4'd5:    val = 24'd6800;
      4'd6:    val = 24'd15000;
      4'd7:    val = 24'd33000;
      4'd8:    val = 24'd68000;
      4'd9:    val = 24'd100000;
      4'd10:   val = 24'd220000;
      4'd11:   val = 24'd330000;
      4'd12:   val = 24'd680000;
      4'd13:   val = 24'd1000000;
      4'd14:   val = 24'd2200000;
      4'd15:   val = 24'd4700000;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ hdl/cbts_datapath.sv @@
// ----------------------------------------------------------------------------
// cbts_datapath
// Running total, switch word and trial compare, plus the output register.
// ----------------------------------------------------------------------------
module cbts_datapath (
  input  logic                        clk_i,
  input  cbts_pkg::cbts_cmd_t         cmd_i,
  input  logic [cbts_pkg::TargetW-1:0] target_pf_i,
  output logic [cbts_pkg::WordW-1:0]   switch_word_o,
  output logic [cbts_pkg::TargetW-1:0] total_pf_o
);
  import cbts_pkg::*;

  logic [TargetW-1:0] target_q;
  logic [TargetW-1:0] total_q, total_d;
  logic [WordW-1:0]   word_q, word_d;
  logic [TargetW-1:0] trial;
  logic [WordW-1:0]   out_word_q;
  logic [TargetW-1:0] out_total_q;

  // The full bank sums to under 2^24, so the trial total cannot overflow.
  always_comb begin
    trial   = total_q + cap_pf(cmd_i.idx);
    total_d = total_q;
    word_d  = word_q;
    if (trial <= target_q) begin
      total_d = trial;
      word_d  = word_q | (WordW'(1) << cmd_i.idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      target_q <= target_pf_i;
      total_q  <= '0;
      word_q   <= '0;
    end else if (cmd_i.step) begin
      total_q  <= total_d;
      word_q   <= word_d;
    end
    if (cmd_i.load_out) begin
      out_word_q  <= word_d;
      out_total_q <= total_d;
    end
  end

  assign switch_word_o = out_word_q;
  assign total_pf_o    = out_total_q;

endmodule

@@ hdl/cbts_controller.sv @@
// ----------------------------------------------------------------------------
// cbts_controller
// Sequences the bit trials from the top switch down and owns both handshakes.
// ----------------------------------------------------------------------------
module cbts_controller #(
  parameter int NUM_SWITCHES = cbts_pkg::NumSwitchesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cbts_pkg::cbts_cmd_t cmd_o
);
  import cbts_pkg::*;

  localparam logic [RomIdxW-1:0] TopIdx = RomIdxW'(NUM_SWITCHES - 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e             state_q, state_d;
  logic [RomIdxW-1:0] idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  logic               last, out_free;

  always_comb begin
    last        = (idx_q == '0);
    out_free    = !out_valid_q || !out_stall_i;
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.idx   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          idx_d       = TopIdx;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!last) begin
          cmd_o.step = 1'b1;
          idx_d      = idx_q - 1'b1;
        end else if (out_free) begin
          cmd_o.step     = 1'b1;
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/capacitor_bank_tuning_search_core.sv @@
// ----------------------------------------------------------------------------
// capacitor_bank_tuning_search_core
// Throughput: the single trial adder and compare decide one switch bit per
//   cycle, holding on the last bit while the previous result is stalled.
// Reset: rst_ni is asynchronous and active low; it clears the controller
//   state and the output valid. The datapath registers need no reset.
// ----------------------------------------------------------------------------
//
// The search is a greedy successive approximation over a fixed bank of
// capacitors. Starting from the highest switch in use, each cycle adds that
// capacitor to the running total and keeps the switch when the trial total
// does not exceed the target. The outcome is not above the target, but is not
// always the largest sum nor the nearest; a zero target yields an all-open word.
//
// The controller accepts a word only while it is idle. The final bit decision
// is written straight into the output register, which lets a result wait for
// the downstream side while the next input word is already being accepted.
// Should the previous result still be stalled when the last bit is reached,
// the controller holds on that bit until the output register frees up.
//
// Switch bits at or above NUM_SWITCHES are never set.
module capacitor_bank_tuning_search_core #(
  parameter int NUM_SWITCHES = cbts_pkg::NumSwitchesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [cbts_pkg::TargetW-1:0] target_pf_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [cbts_pkg::WordW-1:0]   switch_word_o,
  output logic [cbts_pkg::TargetW-1:0] total_pf_o
);
  import cbts_pkg::*;

  // Command bundle from the sequencer to the arithmetic.
  cbts_cmd_t cmd;

  cbts_controller #(
    .NUM_SWITCHES(NUM_SWITCHES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  cbts_datapath u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .target_pf_i  (target_pf_i),
    .switch_word_o(switch_word_o),
    .total_pf_o   (total_pf_o)
  );

endmodule

@@ verif/capacitor_bank_tuning_search_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// capacitor_bank_tuning_search_core_test
// Self-checking bench for the greedy capacitor bank search. A short table of
// corner targets runs first. Random targets follow: exact bank sums and their
// neighbours, values across the bank range, small values and raw 24-bit words.
// Every result word is checked against its table row or a predictor of the search.
// ----------------------------------------------------------------------------
module capacitor_bank_tuning_search_core_test;
  import cbts_pkg::*;

  localparam int NumSwitches = 16;
  localparam int NumDirected = 21;
  localparam int RandomWords = 650;
  localparam int CycleLimit  = 200000;
  localparam int SearchCycles = NumSwitches;

  // Bank values in whole picofarads, index 0 is the smallest capacitor.
  localparam int unsigned BankPf [16] = '{
    150, 330, 680, 1500, 3300, 6800, 15000, 33000,
    68000, 100000, 220000, 330000, 680000, 1000000, 2200000, 4700000
  };

  typedef struct packed {
    logic [WordW-1:0]   switches;
    logic [TargetW-1:0] total;
  } tuning_t;

  // One row of the directed table. Where typed is set, the expected tuning is
  // given in the row; otherwise it comes from the predictor.
  typedef struct packed {
    logic [TargetW-1:0] target;
    logic               typed;
    tuning_t            tuning;
  } directed_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [TargetW-1:0] target_pf_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [WordW-1:0]   switch_word_o;
  logic [TargetW-1:0] total_pf_o;

  // Tunings predicted for accepted targets, oldest first.
  tuning_t pending_tunings [$];
  int      tunings_checked = 0;
  int      fault_count     = 0;

  capacitor_bank_tuning_search_core #(
    .NUM_SWITCHES(NumSwitches)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .target_pf_i  (target_pf_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .switch_word_o(switch_word_o),
    .total_pf_o   (total_pf_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Greedy successive approximation: from the largest capacitor in use down
  // to the smallest, keep a switch closed when the running total with that
  // capacitor added still does not exceed the target.
  function automatic tuning_t search_bank(input logic [TargetW-1:0] target);
    tuning_t          found;
    logic [TargetW:0] trial;
    found = '0;
    for (int k = NumSwitches - 1; k >= 0; k--) begin
      trial = {1'b0, found.total} + (TargetW + 1)'(BankPf[k]);
      if (trial <= {1'b0, target}) begin
        found.total       = trial[TargetW-1:0];
        found.switches[k] = 1'b1;
      end
    end
    return found;
  endfunction

  // Offers one target word and holds it until the block takes it. A random
  // gap of idle cycles goes in front unless the caller asks for a calm run.
  // The expected tuning is queued at the accepting edge, ahead of the result.
  task automatic offer_target(input logic [TargetW-1:0] target, input tuning_t want,
                              input bit calm);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 21) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    target_pf_i <= target;
    // Stall is sampled in the active region of the edge, so the value read
    // is the one the block presented when the edge arrived.
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_tunings.push_back(want);
  endtask

  // Sending side: reset, the directed table, then the random words.
  initial begin : drive_side
    directed_row_t      rows [NumDirected];
    logic [TargetW-1:0] target;
    logic [WordW-1:0]   pick;
    int                 mode;
    rows = '{
      // Zero target leaves every switch open.
      '{24'd0,        1'b1, '{16'h0000, 24'd0}},
      // Below the smallest capacitor, same as a zero target.
      '{24'd149,      1'b1, '{16'h0000, 24'd0}},
      '{24'd1,        1'b1, '{16'h0000, 24'd0}},
      '{24'd150,      1'b1, '{16'h0001, 24'd150}},
      '{24'd151,      1'b1, '{16'h0001, 24'd150}},
      '{24'd329,      1'b0, '0},
      '{24'd330,      1'b1, '{16'h0002, 24'd330}},
      '{24'd480,      1'b1, '{16'h0003, 24'd480}},
      '{24'd4700000,  1'b1, '{16'h8000, 24'd4700000}},
      '{24'd4699999,  1'b0, '0},
      // The full bank and everything above it closes every switch.
      '{24'd9358760,  1'b1, '{16'hFFFF, 24'd9358760}},
      '{24'd9358761,  1'b1, '{16'hFFFF, 24'd9358760}},
      '{24'hFFFFFF,   1'b1, '{16'hFFFF, 24'd9358760}},
      // One short of the full bank drops only the smallest capacitor.
      '{24'd9358759,  1'b1, '{16'hFFFE, 24'd9358610}},
      '{24'h800000,   1'b0, '0},
      '{24'h7FFFFF,   1'b0, '0},
      '{24'hAAAAAA,   1'b0, '0},
      '{24'h555555,   1'b0, '0},
      '{24'd1000000,  1'b0, '0},
      // The sum of the lower fourteen capacitors: greedy takes the 2.2 uF
      // part first and does not land back on that sum.
      '{24'd2458760,  1'b0, '0},
      '{24'd458759,   1'b0, '0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDirected; r++) begin
      offer_target(rows[r].target,
                   rows[r].typed ? rows[r].tuning : search_bank(rows[r].target), 1'b0);
    end

    for (int n = 0; n < RandomWords; n++) begin
      // Once during the run the sender stops until every result is home.
      if (n == 430) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_tunings.size() != 0) @(posedge clk_i);
      end
      mode = $urandom_range(99);
      if (mode < 35) begin
        // An exact bank sum, or one either side of it.
        pick   = WordW'($urandom_range(16'hFFFF));
        target = '0;
        for (int k = 0; k < NumSwitches; k++) begin
          if (pick[k]) target = target + TargetW'(BankPf[k]);
        end
        case ($urandom_range(2))
          0:       target = target - 1'b1;
          2:       target = target + 1'b1;
          default: ;
        endcase
      end else if (mode < 70) begin
        target = TargetW'($urandom_range(9359760));
      end else if (mode < 85) begin
        target = TargetW'($urandom_range(5000));
      end else begin
        target = TargetW'($urandom);
      end
      // Words 250 to 349 go out back to back with no idle cycles.
      offer_target(target, search_bank(target), n >= 250 && n < 350);
    end
    in_valid_i <= 1'b0;

    while (pending_tunings.size() != 0) @(posedge clk_i);
    // Anything arriving now is a result nobody asked for.
    repeat (3 * SearchCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiving side: checks each accepted result word and drives the stall.
  // After 150 results it keeps the stall up once while hold_left counts down, so
  // that the block fills up and stalls the sender. From result 350 to 449 it
  // never stalls; elsewhere it stalls on about 21 percent of cycles.
  always @(posedge clk_i) begin : receive_side
    tuning_t want;
    int      hold_left;
    bit      hold_done;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_tunings.size() == 0) begin
          if (fault_count < 10) begin
            $display("%0t: unexpected result: switches %h total %0d", $realtime,
                     switch_word_o, total_pf_o);
          end
          fault_count++;
        end else begin
          want = pending_tunings.pop_front();
          if (switch_word_o !== want.switches || total_pf_o !== want.total) begin
            if (fault_count < 10) begin
              $display("%0t: result %0d: switches %h total %0d, expected %h total %0d",
                       $realtime, tunings_checked, switch_word_o, total_pf_o,
                       want.switches, want.total);
            end
            fault_count++;
          end
        end
        tunings_checked++;
      end

      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && tunings_checked >= 150) begin
        hold_done = 1'b1;
        hold_left = 299;
        out_stall_i <= 1'b1;
      end else if (tunings_checked >= 350 && tunings_checked < 450) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 21);
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
